// ===== sv/pidc_pkg.sv =====
// Shared types and constants for the PID step core.
`default_nettype none
package pidc_pkg;
   localparam int ErrWidth = 18;
   localparam int AccWidth = 72;
   localparam int DerivWidth = 28;
   localparam logic [9:0] MsPerSecond = 10'd1000;

   localparam logic [2:0] RegPropGain = 3'd0;
   localparam logic [2:0] RegIntegGain = 3'd1;
   localparam logic [2:0] RegDerivGain = 3'd2;
   localparam logic [2:0] RegDriveOffset = 3'd3;
   localparam logic [2:0] RegIntegLimit = 3'd4;
   localparam logic [2:0] RegWindowLow = 3'd5;
   localparam logic [2:0] RegWindowHigh = 3'd6;

   typedef struct packed {
      logic action;
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] prop_gain;
      logic signed [31:0] integ_gain;
      logic signed [31:0] deriv_gain;
      logic signed [15:0] drive_offset;
      logic [30:0] integ_limit;
      logic [15:0] window_low;
      logic [15:0] window_high;
   } cfg_type;
endpackage
`default_nettype wire

// ===== sv/pidc_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, 72-bit product.
`default_nettype none
module pidc_serial_mul
   import pidc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [31:0] mcand,
   input  wire logic signed [39:0] mplier,
   output logic done,
   output logic signed [AccWidth-1:0] product
);
   logic [5:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic signed [AccWidth-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [39:0] mp_ff, mp_in;
   logic signed [AccWidth-1:0] step_acc;

   always_comb begin
      // Top bit carries negative weight.
      step_acc = acc_ff;
      if (mp_ff[0]) begin
         if (count_ff == 6'd39) step_acc = acc_ff - mc_ff;
         else step_acc = acc_ff + mc_ff;
      end
      done = busy_ff && (count_ff == 6'd39);
      count_in = count_ff;
      busy_in = busy_ff;
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      if (busy_ff) begin
         acc_in = step_acc;
         mc_in = mc_ff <<< 1;
         mp_in = mp_ff >> 1;
         count_in = count_ff + 6'd1;
         if (done) busy_in = 1'b0;
      end
      // A new start may land on the last cycle of the previous product.
      if (start) begin
         busy_in = 1'b1;
         count_in = 6'd0;
         acc_in = '0;
         mc_in = AccWidth'(mcand);
         mp_in = mplier;
      end
   end

   assign product = step_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
   end
endmodule
`default_nettype wire

// ===== sv/pidc_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating signed quotient.
`default_nettype none
module pidc_serial_div
   import pidc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [DerivWidth-1:0] dividend,
   input  wire logic [15:0] divisor,
   output logic done,
   output logic signed [DerivWidth-1:0] quotient
);
   logic [4:0] count_ff, count_in;
   logic busy_ff, busy_in, neg_ff, neg_in;
   logic [DerivWidth-1:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in, trial;
   logic [15:0] dsr_ff, dsr_in;
   logic [DerivWidth-1:0] mag;

   always_comb begin
      mag = dividend[DerivWidth-1] ? DerivWidth'(-dividend) : dividend;
      count_in = count_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      done = 1'b0;
      trial = {rem_ff[15:0], quo_ff[DerivWidth-1]};
      if (start) begin
         busy_in = 1'b1;
         count_in = '0;
         neg_in = dividend[DerivWidth-1];
         quo_in = mag;
         rem_in = '0;
         dsr_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DerivWidth-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(DerivWidth - 1)) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   assign quotient = neg_ff ? DerivWidth'(-quo_in) : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end
endmodule
`default_nettype wire

// ===== sv/pid_controller_step_core.sv =====
// Top level of the PID step core: register file, sequencer and serial units.
// Sequence: a clear item answers in the cycle after acceptance; a control step
//   runs a serial divide (skipped with zero elapsed time), an update step,
//   three serial multiplies and an output step.
// Throughput: one item at a time; the next item is taken once the result
//   register is free and the sequencer is back in idle.
// Reset (synchronous, active high) zeroes the registers, integral and
//   previous error, and drops the result valid flag.
`default_nettype none
module pid_controller_step_core
   import pidc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type rsp_data,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [4:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_UPD  = 7'b0000100,
      S_MULP = 7'b0001000,
      S_MULI = 7'b0010000,
      S_MULD = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   cfg_type cfg_ff, cfg_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [ErrWidth-1:0] last_ff, last_in, err_ff, err_in;
   logic [15:0] dt_ff, dt_in;
   logic signed [DerivWidth-1:0] deriv_ff, deriv_in;
   logic signed [AccWidth-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic csr_write;
   logic [2:0] csr_index;
   logic div_start, div_done, mul_start, mul_done;
   logic signed [DerivWidth-1:0] div_q;
   logic signed [AccWidth-1:0] mul_p;
   logic signed [31:0] mul_a;
   logic signed [39:0] mul_b;
   logic signed [ErrWidth-1:0] req_err, err_mag;
   logic signed [33:0] sum;
   logic signed [32:0] lim;
   logic signed [55:0] shifted;
   logic signed [56:0] drive_wide;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[4:2];

   // Register file: writes beyond the list drop.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            RegPropGain: cfg_in.prop_gain = csr_pwdata;
            RegIntegGain: cfg_in.integ_gain = csr_pwdata;
            RegDerivGain: cfg_in.deriv_gain = csr_pwdata;
            RegDriveOffset: cfg_in.drive_offset = csr_pwdata[15:0];
            RegIntegLimit: cfg_in.integ_limit = csr_pwdata[30:0];
            RegWindowLow: cfg_in.window_low = csr_pwdata[15:0];
            RegWindowHigh: cfg_in.window_high = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegPropGain: csr_prdata = cfg_ff.prop_gain;
         RegIntegGain: csr_prdata = cfg_ff.integ_gain;
         RegDerivGain: csr_prdata = cfg_ff.deriv_gain;
         RegDriveOffset: csr_prdata = 32'(cfg_ff.drive_offset);
         RegIntegLimit: csr_prdata = {1'b0, cfg_ff.integ_limit};
         RegWindowLow: csr_prdata = {16'd0, cfg_ff.window_low};
         RegWindowHigh: csr_prdata = {16'd0, cfg_ff.window_high};
         default: csr_prdata = '0;
      endcase
   end

   // Take a new item only from idle with the result register free.
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign req_err = ErrWidth'(req_data.setpoint) - ErrWidth'(req_data.measured);
   assign err_mag = err_ff[ErrWidth-1] ? -err_ff : err_ff;

   assign div_start = (state_ff == S_IDLE) && req_valid && req_ready
      && !req_data.action && (req_data.elapsed_ms != 16'd0);

   pidc_serial_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(DerivWidth'(req_err - last_ff) * DerivWidth'(MsPerSecond)),
      .divisor(req_data.elapsed_ms), .done(div_done), .quotient(div_q)
   );

   // Operands for the product that starts in this state: the proportional
   // term starts from the update step, each later term as the previous ends.
   always_comb begin
      case (state_ff)
         S_MULP: begin
            mul_a = cfg_ff.integ_gain;
            mul_b = 40'(integ_ff);
         end
         S_MULI: begin
            mul_a = cfg_ff.deriv_gain;
            mul_b = 40'(deriv_ff);
         end
         default: begin
            mul_a = cfg_ff.prop_gain;
            mul_b = 40'(err_ff);
         end
      endcase
   end

   pidc_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(mul_a), .mplier(mul_b), .done(mul_done), .product(mul_p)
   );

   always_comb begin
      state_in = state_ff;
      integ_in = integ_ff;
      last_in = last_ff;
      err_in = err_ff;
      dt_in = dt_ff;
      deriv_in = deriv_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      mul_start = 1'b0;
      sum = 34'(integ_ff) + 34'(err_ff) * 34'($signed({1'b0, dt_ff}));
      lim = 33'(cfg_ff.integ_limit);
      shifted = 56'(acc_ff >>> 16);
      drive_wide = 57'(shifted) + 57'(cfg_ff.drive_offset);
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.action) begin
                  integ_in = '0;
                  last_in = '0;
                  rsp_in = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  err_in = req_err;
                  dt_in = req_data.elapsed_ms;
                  deriv_in = '0;
                  state_in = (req_data.elapsed_ms != 16'd0) ? S_DIV : S_UPD;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               deriv_in = div_q;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            // Window, clamp and zero-error rules on the integral.
            if (!(err_mag > ErrWidth'({1'b0, cfg_ff.window_low})
                  && err_mag < ErrWidth'({1'b0, cfg_ff.window_high})))
               sum = 34'(integ_ff);
            if (sum > 34'(lim)) sum = 34'(lim);
            else if (sum < -34'(lim)) sum = -34'(lim);
            integ_in = (err_ff == '0) ? '0 : 32'(sum);
            last_in = err_ff;
            acc_in = '0;
            mul_start = 1'b1;
            state_in = S_MULP;
         end
         S_MULP: begin
            if (mul_done) begin
               acc_in = acc_ff + mul_p;
               mul_start = 1'b1;
               state_in = S_MULI;
            end
         end
         S_MULI: begin
            if (mul_done) begin
               acc_in = acc_ff + mul_p;
               mul_start = 1'b1;
               state_in = S_MULD;
            end
         end
         S_MULD: begin
            if (mul_done) begin
               acc_in = acc_ff + mul_p;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Saturate to 16 bits and flag the clip.
            if (drive_wide > 57'sd32767) begin
               rsp_in.drive = 16'sh7FFF;
               rsp_in.saturated = 1'b1;
            end else if (drive_wide < -57'sd32768) begin
               rsp_in.drive = 16'sh8000;
               rsp_in.saturated = 1'b1;
            end else begin
               rsp_in.drive = drive_wide[15:0];
               rsp_in.saturated = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_ff <= '0;
         integ_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         integ_ff <= integ_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff <= err_in;
      dt_ff <= dt_in;
      deriv_ff <= deriv_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MULP) |-> (integ_ff <= $signed({1'b0, cfg_ff.integ_limit})
         && integ_ff >= -$signed({1'b0, cfg_ff.integ_limit})))
      else $error("integral outside limit");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("input taken while busy");
   a_result_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid)
      else $error("missing result");
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.drive == 16'sh7FFF || rsp_data.drive == 16'sh8000))
      else $error("bad saturation value");
`endif
endmodule
`default_nettype wire
